// File: sv/olt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg: shared types and constants of the ordered list table
// Request and result payloads, request kinds, status codes, the cell
// control group and the scanner status.
// ----------------------------------------------------------------------------
package olt_pkg;

	localparam int OLT_CAPACITY = 64;   // default list capacity
	localparam int OLT_SCAN_W   = 8;    // match bits examined per find cycle

	// request kinds
	localparam logic [2:0] K_INSERT_AT  = 3'd0;
	localparam logic [2:0] K_ERASE_AT   = 3'd1;
	localparam logic [2:0] K_FIND       = 3'd2;
	localparam logic [2:0] K_PUSH_BACK  = 3'd3;
	localparam logic [2:0] K_PUSH_FRONT = 3'd4;
	localparam logic [2:0] K_POP_BACK   = 3'd5;
	localparam logic [2:0] K_POP_FRONT  = 3'd6;

	// status codes
	localparam logic [2:0] S_OK        = 3'd0;
	localparam logic [2:0] S_FULL      = 3'd1;
	localparam logic [2:0] S_EMPTY     = 3'd2;
	localparam logic [2:0] S_BAD_POS   = 3'd3;
	localparam logic [2:0] S_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic [6:0]         position;
		logic signed [31:0] value;
	} olt_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] found_index;
		logic [6:0] entry_count;
	} olt_rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic ins;   // open a gap at the position and load the value
		logic ers;   // close the gap at the position
	} olt_cell_ctl_t;

	// scanner status towards the control
	typedef struct packed {
		logic done;
		logic hit;
	} olt_scan_st_t;

endpackage
`default_nettype wire

// File: sv/ordered_list_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_table: ordered list of signed 32-bit values
// A row of CAPACITY cells with a count; insert, erase, find and the push/pop
// requests, one result per request.
// ----------------------------------------------------------------------------
// The list lives in a chain of CAPACITY cells, one entry each. On insert,
// erase, push and pop requests every cell from the position on copies its
// neighbour at once (insert loads the value at the position; pop back only
// lowers the count); the result goes on the same edge to the output register,
// or to the catch register if the output is stalled. Find: the cells compare
// in parallel and the match row is latched, then a scanner walks it eight
// entries per cycle and stops on the first chunk holding a match. A request
// that cannot be done (full list, empty list, position out of range) leaves
// the list untouched and reports the reason in status; kind 7 is a no-op
// with status ok. One request is in flight at a time; a stalled result goes
// to a catch register, and only a full one holds off requests. entry_count
// and found_index carry the low bits only if CAPACITY exceeds their widths.
// ----------------------------------------------------------------------------
module ordered_list_table #(
	parameter int CAPACITY = olt_pkg::OLT_CAPACITY
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	output logic                    req_ready,
	input  wire olt_pkg::olt_req_t  req,
	output logic                    rsp_valid,
	input  wire                     rsp_ready,
	output olt_pkg::olt_rsp_t       rsp
);
	import olt_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);   // count width
	localparam int IW   = $clog2(CAPACITY);       // index width
	localparam int CMPW = (CW > 7) ? CW : 7;      // position compare width

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_FIND = 1'b1;

	logic               st_q;
	logic [CW-1:0]      cnt_q;

	// output register and its catch register
	logic               out_valid_q;
	olt_rsp_t           out_q;
	logic               hold_valid_q;
	olt_rsp_t           hold_q;

	logic               take;
	logic               full, empty;
	logic [CMPW-1:0]    pos_x, cnt_x;
	olt_cell_ctl_t      ctl;
	logic [CW-1:0]      op_pos;
	logic [CW-1:0]      cnt_d;
	logic               res_valid;
	olt_rsp_t           res;
	logic               scan_start;

	logic signed [31:0] cell_data  [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	olt_scan_st_t       scan_st;
	logic [IW-1:0]      scan_idx;

	assign req_ready = (st_q == ST_IDLE) && !hold_valid_q;
	assign take      = req_valid && req_ready;

	assign full  = (cnt_q == CW'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign pos_x = CMPW'(req.position);
	assign cnt_x = CMPW'(cnt_q);

	// request decode: cell commands, new count, scan start and the result, or the scanner result at the end of a find
	always_comb begin
		ctl        = '0;
		op_pos     = CW'(req.position);
		cnt_d      = cnt_q;
		scan_start = 1'b0;
		res        = '0;
		res_valid  = 1'b0;
		if (take) begin
			res_valid  = 1'b1;
			res.status = S_OK;
			case (req.kind)
				K_INSERT_AT: begin
					if (full) begin
						res.status = S_FULL;
					end else if (pos_x > cnt_x) begin
						res.status = S_BAD_POS;
					end else begin
						ctl.ins = 1'b1;
						cnt_d   = cnt_q + 1'b1;
					end
				end
				K_ERASE_AT: begin
					if (empty) begin
						res.status = S_EMPTY;
					end else if (pos_x >= cnt_x) begin
						res.status = S_BAD_POS;
					end else begin
						ctl.ers = 1'b1;
						cnt_d   = cnt_q - 1'b1;
					end
				end
				K_FIND: begin
					// result comes from the scanner
					res_valid  = 1'b0;
					scan_start = 1'b1;
				end
				K_PUSH_BACK: begin
					if (full) begin
						res.status = S_FULL;
					end else begin
						ctl.ins = 1'b1;
						op_pos  = cnt_q;
						cnt_d   = cnt_q + 1'b1;
					end
				end
				K_PUSH_FRONT: begin
					if (full) begin
						res.status = S_FULL;
					end else begin
						ctl.ins = 1'b1;
						op_pos  = '0;
						cnt_d   = cnt_q + 1'b1;
					end
				end
				K_POP_BACK: begin
					if (empty) begin
						res.status = S_EMPTY;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
				K_POP_FRONT: begin
					if (empty) begin
						res.status = S_EMPTY;
					end else begin
						ctl.ers = 1'b1;
						op_pos  = '0;
						cnt_d   = cnt_q - 1'b1;
					end
				end
				default: begin
					// unused kind: no change, status ok
				end
			endcase
			res.entry_count = 7'(cnt_d);
		end else if ((st_q == ST_FIND) && scan_st.done) begin
			res_valid       = 1'b1;
			res.status      = scan_st.hit ? S_OK : S_NOT_FOUND;
			res.found_index = scan_st.hit ? 6'(scan_idx) : 6'd0;
			res.entry_count = 7'(cnt_q);
		end
	end

	// the cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_w, next_w;
		if (i == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_prev
			assign prev_w = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_next
			assign next_w = cell_data[i+1];
		end
		olt_cell #(
			.CW    (CW),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.op_pos    (op_pos),
			.count     (cnt_q),
			.value     (req.value),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[i]),
			.match     (cell_match[i])
		);
	end

	olt_scan #(
		.CAPACITY (CAPACITY),
		.IW       (IW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_start),
		.match_in (cell_match),
		.st       (scan_st),
		.index    (scan_idx)
	);

	// control state and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
			case (st_q)
				ST_IDLE: begin
					if (scan_start) begin
						st_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (scan_st.done) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result transfer: output register first, catch register when the output register holds a result not taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (res_valid) begin
			if (!out_valid_q || rsp_ready) begin
				out_valid_q <= 1'b1;
			end else begin
				hold_valid_q <= 1'b1;
			end
		end else if (out_valid_q && rsp_ready) begin
			out_valid_q  <= hold_valid_q;
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			if (!out_valid_q || rsp_ready) begin
				out_q <= res;
			end else begin
				hold_q <= res;
			end
		end else if (out_valid_q && rsp_ready) begin
			out_q <= hold_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
`default_nettype wire

// File: sv/olt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olt_cell: one list slot
// Holds one entry; shifts from a neighbour, loads the broadcast value, and
// compares its entry against the broadcast value.
// ----------------------------------------------------------------------------
module olt_cell #(
	parameter int CW    = 7,
	parameter int INDEX = 0
) (
	input  wire                         clk,
	input  wire olt_pkg::olt_cell_ctl_t ctl,
	input  wire [CW-1:0]                op_pos,
	input  wire [CW-1:0]                count,
	input  wire logic signed [31:0]     value,
	input  wire logic signed [31:0]     prev_data,
	input  wire logic signed [31:0]     next_data,
	output logic signed [31:0]          data,
	output logic                        match
);
	import olt_pkg::*;

	localparam logic [CW-1:0] IDX = CW'(INDEX);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (IDX == op_pos) begin
				data_q <= value;
			end else if (IDX > op_pos) begin
				data_q <= prev_data;
			end
		end else if (ctl.ers && (IDX >= op_pos)) begin
			data_q <= next_data;
		end
	end

	assign data  = data_q;
	// only live slots take part in a find
	assign match = (IDX < count) && (data_q == value);

endmodule
`default_nettype wire

// File: sv/olt_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olt_scan: first-match scanner
// Latches the match row of the cells and walks it a chunk per cycle,
// lowest index first.
// ----------------------------------------------------------------------------
module olt_scan #(
	parameter int CAPACITY = olt_pkg::OLT_CAPACITY,
	parameter int IW       = $clog2(olt_pkg::OLT_CAPACITY)
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire [CAPACITY-1:0]      match_in,
	output olt_pkg::olt_scan_st_t   st,
	output logic [IW-1:0]           index
);
	import olt_pkg::*;

	localparam int NCH = (CAPACITY + OLT_SCAN_W - 1) / OLT_SCAN_W;
	localparam int PW  = NCH * OLT_SCAN_W;
	localparam int CHW = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SBW = $clog2(OLT_SCAN_W);

	logic [PW-1:0]          match_q;
	logic [CHW-1:0]         ch_q;
	logic                   busy_q;
	logic [OLT_SCAN_W-1:0]  chunk;
	logic [SBW-1:0]         sel;
	logic                   last;

	assign chunk = match_q[ch_q*OLT_SCAN_W +: OLT_SCAN_W];
	assign last  = (ch_q == CHW'(NCH - 1));

	// lowest set bit of the chunk
	always_comb begin
		sel = '0;
		for (int b = OLT_SCAN_W - 1; b >= 0; b--) begin
			if (chunk[b]) begin
				sel = SBW'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			match_q <= PW'(match_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			ch_q   <= '0;
		end else if (busy_q) begin
			if ((chunk != '0) || last) begin
				busy_q <= 1'b0;
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	assign st.done = busy_q && ((chunk != '0) || last);
	assign st.hit  = (chunk != '0);
	assign index   = IW'({ch_q, sel});

endmodule
`default_nettype wire

// File: sv/olt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olt_checker: port checks for the ordered list table
// Watches the request and result channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module olt_checker #(
	parameter int CAPACITY = olt_pkg::OLT_CAPACITY
) (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      req_valid,
	input wire                      req_ready,
	input wire olt_pkg::olt_req_t   req,
	input wire                      rsp_valid,
	input wire                      rsp_ready,
	input wire olt_pkg::olt_rsp_t   rsp
);
	import olt_pkg::*;

	localparam logic [6:0] CAP7 = 7'(CAPACITY);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// full only ever reported on a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == S_FULL) |-> rsp.entry_count == CAP7)
		else $error("full status with list not full");

	// empty only ever reported on an empty list
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == S_EMPTY) |-> rsp.entry_count == 7'd0)
		else $error("empty status with entries held");

	// a found index is only given with a successful find
	a_idx_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.found_index != 6'd0) |-> rsp.status == S_OK)
		else $error("found index with failing status");

	// a find holds off the next request
	a_req_hs: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && req_valid && (req.kind == K_FIND) |=> !req_ready)
		else $error("request taken during a find");

endmodule

bind ordered_list_table olt_checker #(
	.CAPACITY (CAPACITY)
) u_olt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire
